// File: sv/iiee_pkg.sv
package iiee_pkg;

    localparam int DataWidth = 32;
    localparam int KindWidth = 3;
    localparam int DefaultStackDepth = 16;

    localparam logic [KindWidth-1:0] KIND_NUM   = 3'd0;
    localparam logic [KindWidth-1:0] KIND_OPEN  = 3'd1;
    localparam logic [KindWidth-1:0] KIND_CLOSE = 3'd2;
    localparam logic [KindWidth-1:0] KIND_ADD   = 3'd3;
    localparam logic [KindWidth-1:0] KIND_SUB   = 3'd4;
    localparam logic [KindWidth-1:0] KIND_MUL   = 3'd5;
    localparam logic [KindWidth-1:0] KIND_DIV   = 3'd6;
    localparam logic [KindWidth-1:0] KIND_END   = 3'd7;

    // precedence class: open bracket lowest, then add/sub, then mul/div; other kinds zero
    function automatic logic [1:0] prec_of(input logic [KindWidth-1:0] kind);
        logic [1:0] p;
        case (kind)
            KIND_OPEN:            p = 2'd1;
            KIND_ADD, KIND_SUB:   p = 2'd2;
            KIND_MUL, KIND_DIV:   p = 2'd3;
            default:              p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// File: sv/infix_integer_expression_evaluator.sv
// Infix integer expression evaluator.
// Input channel: token_kind / token_value with in_valid and in_stall. Tokens
// of one expression arrive in order; the end token closes the expression.
// Output channel: result_value / error_flag with out_valid and out_stall; one
// result per end token, zero value with error_flag set on any error.
// Both stacks live in synchronous memories with registered read data.
// A number or open bracket is handled as it is transferred. An operator or close
// bracket is transferred, then the top operator is read and a decision made, and
// each reduction adds its own steps (read operator, read two operands, compute, write
// back); a divide also runs the one-bit-per-cycle divider. An end token also reads
// the number stack after its reductions, and its result then goes to the output register.
// The next token is taken only when the previous one is done; a result waits
// in the output register while the next expression's tokens are accepted,
// and an end token is held off while that register is still full.
// Reset clears depths, the error latch and the output register; memory
// contents are left undefined and never read before written.
module infix_integer_expression_evaluator
    import iiee_pkg::*;
#(
    parameter int STACK_DEPTH = DefaultStackDepth
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [KindWidth-1:0]        token_kind,
    input  logic signed [DataWidth-1:0] token_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DataWidth-1:0] result_value,
    output logic                        error_flag
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_TOP, S_TOPW, S_DEC, S_RD1, S_RD2, S_RDW, S_EXEC,
        S_DIV, S_WB, S_FIN, S_FINW
    } state_t;

    logic [KindWidth-1:0] op_mem [STACK_DEPTH];
    logic [DataWidth-1:0] num_mem [STACK_DEPTH];

    state_t               state_reg;
    logic [DW-1:0]        op_depth_reg, num_depth_reg;
    logic                 err_reg;
    logic [KindWidth-1:0] kind_reg;
    logic [KindWidth-1:0] top_op_reg;
    logic [KindWidth-1:0] op_rd_reg;
    logic [DataWidth-1:0] num_rd_reg;
    logic [DataWidth-1:0] l_reg, r_reg, res_reg;
    logic                 out_valid_reg;
    logic [DataWidth-1:0] out_value_reg;
    logic                 out_err_reg;

    // divider
    logic [DataWidth-1:0] dq_reg, drem_reg, dmb_reg;
    logic [5:0]           dcnt_reg;
    logic                 dneg_reg;

    // memory ports
    logic                 op_we, num_we;
    logic [AW-1:0]        op_wa, op_ra, num_wa, num_ra;
    logic [KindWidth-1:0] op_wd;
    logic [DataWidth-1:0] num_wd;

    logic accept;
    assign in_stall = (state_reg != S_IDLE) || (token_kind == KIND_END && out_valid_reg);
    assign accept   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign error_flag   = out_err_reg;

    always_ff @(posedge clk)
    begin
        if (op_we)
        begin
            op_mem[op_wa] <= op_wd;
        end
        if (num_we)
        begin
            num_mem[num_wa] <= num_wd;
        end
        op_rd_reg  <= op_mem[op_ra];
        num_rd_reg <= num_mem[num_ra];
    end

    logic [DataWidth-1:0] ma, mb, drem_sh, dsub;
    logic [DataWidth-1:0] prod;
    assign ma      = l_reg[DataWidth-1] ? (~l_reg + 1'b1) : l_reg;
    assign mb      = r_reg[DataWidth-1] ? (~r_reg + 1'b1) : r_reg;
    assign prod    = l_reg * r_reg;
    assign drem_sh = {drem_reg[DataWidth-2:0], dq_reg[DataWidth-1]};
    assign dsub    = drem_sh - dmb_reg;

    logic reduce_ok;
    assign reduce_ok = (op_depth_reg != '0) && (num_depth_reg >= DW'(2));

    always_comb
    begin
        op_we  = 1'b0;
        num_we = 1'b0;
        op_wa  = op_depth_reg[AW-1:0];
        op_wd  = kind_reg;
        num_wa = num_depth_reg[AW-1:0];
        num_wd = token_value;
        op_ra  = AW'(op_depth_reg - 1'b1);
        num_ra = AW'(num_depth_reg - 1'b1);
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !err_reg)
                begin
                    if (token_kind == KIND_NUM && num_depth_reg < FULL)
                    begin
                        num_we = 1'b1;
                    end
                    if (token_kind == KIND_OPEN && op_depth_reg < FULL)
                    begin
                        op_we = 1'b1;
                        op_wd = KIND_OPEN;
                    end
                end
            end
            S_RD1:
            begin
                num_ra = AW'(num_depth_reg - 2'd2);
            end
            S_WB:
            begin
                num_we = 1'b1;
                num_wa = AW'(num_depth_reg - 2'd2);
                num_wd = res_reg;
            end
            S_DEC:
            begin
                op_we = (kind_reg != KIND_CLOSE) && (kind_reg != KIND_END) &&
                        (op_depth_reg < FULL) &&
                        !(op_depth_reg != '0 && prec_of(top_op_reg) >= prec_of(kind_reg));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_depth_reg  <= '0;
            num_depth_reg <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_err_reg   <= 1'b0;
            out_value_reg <= '0;
            kind_reg      <= KIND_NUM;
            top_op_reg    <= KIND_NUM;
            l_reg         <= '0;
            r_reg         <= '0;
            res_reg       <= '0;
            dq_reg        <= '0;
            drem_reg      <= '0;
            dmb_reg       <= '0;
            dcnt_reg      <= '0;
            dneg_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= token_kind;
                        if (token_kind == KIND_END)
                        begin
                            state_reg <= err_reg ? S_FIN : S_TOP;
                        end
                        else if (!err_reg)
                        begin
                            case (token_kind)
                                KIND_NUM:
                                begin
                                    if (num_depth_reg < FULL)
                                        num_depth_reg <= num_depth_reg + 1'b1;
                                    else
                                        err_reg <= 1'b1;
                                end
                                KIND_OPEN:
                                begin
                                    if (op_depth_reg < FULL)
                                        op_depth_reg <= op_depth_reg + 1'b1;
                                    else
                                        err_reg <= 1'b1;
                                end
                                default:
                                begin
                                    state_reg <= S_TOP;
                                end
                            endcase
                        end
                    end
                end
                S_TOP:
                begin
                    // op_ra addresses the top operator this cycle
                    state_reg <= S_TOPW;
                end
                S_TOPW:
                begin
                    top_op_reg <= op_rd_reg;
                    state_reg  <= S_DEC;
                end
                S_DEC:
                begin
                    state_reg <= S_IDLE;
                    case (kind_reg)
                        KIND_END:
                        begin
                            if (op_depth_reg == '0)
                            begin
                                state_reg <= S_FIN;
                            end
                            else if (!reduce_ok)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_RD1;
                            end
                        end
                        KIND_CLOSE:
                        begin
                            if (op_depth_reg == '0)
                                err_reg <= 1'b1;
                            else if (top_op_reg == KIND_OPEN)
                                op_depth_reg <= op_depth_reg - 1'b1;
                            else if (!reduce_ok)
                                err_reg <= 1'b1;
                            else
                                state_reg <= S_RD1;
                        end
                        default:
                        begin
                            if (op_depth_reg != '0 &&
                                prec_of(top_op_reg) >= prec_of(kind_reg))
                            begin
                                if (!reduce_ok)
                                    err_reg <= 1'b1;
                                else
                                    state_reg <= S_RD1;
                            end
                            else if (op_depth_reg < FULL)
                            begin
                                op_depth_reg <= op_depth_reg + 1'b1;
                            end
                            else
                            begin
                                err_reg <= 1'b1;
                            end
                        end
                    endcase
                end
                S_RD1:
                begin
                    // left operand arrives next cycle, right the cycle after
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    l_reg     <= num_rd_reg;
                    state_reg <= S_RDW;
                end
                S_RDW:
                begin
                    r_reg     <= num_rd_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_WB;
                    case (top_op_reg)
                        KIND_ADD: res_reg <= l_reg + r_reg;
                        KIND_SUB: res_reg <= l_reg - r_reg;
                        KIND_MUL: res_reg <= prod;
                        KIND_DIV:
                        begin
                            if (r_reg == '0)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= (kind_reg == KIND_END) ? S_FIN : S_IDLE;
                            end
                            else
                            begin
                                dq_reg    <= ma;
                                drem_reg  <= '0;
                                dmb_reg   <= mb;
                                dneg_reg  <= l_reg[DataWidth-1] ^ r_reg[DataWidth-1];
                                dcnt_reg  <= 6'(DataWidth);
                                state_reg <= S_DIV;
                            end
                        end
                        default:
                        begin
                            err_reg   <= 1'b1;
                            state_reg <= (kind_reg == KIND_END) ? S_FIN : S_IDLE;
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (dcnt_reg == '0)
                    begin
                        res_reg   <= dneg_reg ? (~dq_reg + 1'b1) : dq_reg;
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (drem_sh >= dmb_reg)
                        begin
                            drem_reg <= dsub;
                            dq_reg   <= {dq_reg[DataWidth-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= drem_sh;
                            dq_reg   <= {dq_reg[DataWidth-2:0], 1'b0};
                        end
                    end
                end
                S_WB:
                begin
                    // pop operator and one number, then look at the new top
                    op_depth_reg  <= op_depth_reg - 1'b1;
                    num_depth_reg <= num_depth_reg - 1'b1;
                    state_reg     <= S_TOP;
                end
                S_FIN:
                begin
                    // read bottom of number stack
                    state_reg <= S_FINW;
                end
                S_FINW:
                begin
                    out_valid_reg <= 1'b1;
                    if (err_reg || num_depth_reg != DW'(1))
                    begin
                        out_err_reg   <= 1'b1;
                        out_value_reg <= '0;
                    end
                    else
                    begin
                        out_err_reg   <= 1'b0;
                        out_value_reg <= num_rd_reg;
                    end
                    op_depth_reg  <= '0;
                    num_depth_reg <= '0;
                    err_reg       <= 1'b0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: dv/iiee_checker.sv
module iiee_checker
    import iiee_pkg::*;
#(
    parameter int STACK_DEPTH = DefaultStackDepth
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [KindWidth-1:0]        token_kind,
    input  logic signed [DataWidth-1:0] token_value,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [DataWidth-1:0] result_value,
    input  logic                        error_flag,
    output int                          fail_count,
    output int                          pending_results
);

    typedef struct packed {
        logic [DataWidth-1:0] value;
        logic                 err;
    } eval_result_t;

    logic [KindWidth-1:0] ops [STACK_DEPTH];
    logic [DataWidth-1:0] nums [STACK_DEPTH];
    int op_top;
    int num_top;
    bit err_seen;
    eval_result_t expected_results[$];

    function automatic int prec_class(input logic [KindWidth-1:0] kind);
        int p;
        case (kind)
            KIND_OPEN:          p = 1;
            KIND_ADD, KIND_SUB: p = 2;
            KIND_MUL, KIND_DIV: p = 3;
            default:            p = 0;
        endcase
        return p;
    endfunction

    function automatic logic [DataWidth-1:0] quot_trunc(input logic [DataWidth-1:0] a,
                                                        input logic [DataWidth-1:0] b);
        logic [DataWidth-1:0] ma;
        logic [DataWidth-1:0] mb;
        logic [DataWidth-1:0] q;
        ma = a[DataWidth-1] ? -a : a;
        mb = b[DataWidth-1] ? -b : b;
        q = ma / mb;
        return (a[DataWidth-1] ^ b[DataWidth-1]) ? -q : q;
    endfunction

    // pop one operator and two operands, push the outcome
    function automatic bit apply_top();
        logic [DataWidth-1:0] l;
        logic [DataWidth-1:0] r;
        logic [DataWidth-1:0] res;
        if (op_top == 0 || num_top < 2)
            return 0;
        r = nums[num_top-1];
        l = nums[num_top-2];
        case (ops[op_top-1])
            KIND_ADD: res = l + r;
            KIND_SUB: res = l - r;
            KIND_MUL: res = l * r;
            KIND_DIV:
            begin
                if (r == 0)
                    return 0;
                res = quot_trunc(l, r);
            end
            default:  return 0;
        endcase
        op_top--;
        num_top--;
        nums[num_top-1] = res;
        return 1;
    endfunction

    function automatic bit take_token(input logic [KindWidth-1:0] kind,
                                      input logic [DataWidth-1:0] value);
        case (kind)
            KIND_NUM:
            begin
                if (num_top >= STACK_DEPTH)
                    return 0;
                nums[num_top++] = value;
                return 1;
            end
            KIND_OPEN:
            begin
                if (op_top >= STACK_DEPTH)
                    return 0;
                ops[op_top++] = KIND_OPEN;
                return 1;
            end
            KIND_CLOSE:
            begin
                forever
                begin
                    if (op_top == 0)
                        return 0;
                    if (ops[op_top-1] == KIND_OPEN)
                        break;
                    if (!apply_top())
                        return 0;
                end
                op_top--;
                return 1;
            end
            default:
            begin
                while (op_top > 0 && prec_class(ops[op_top-1]) >= prec_class(kind))
                    if (!apply_top())
                        return 0;
                if (op_top >= STACK_DEPTH)
                    return 0;
                ops[op_top++] = kind;
                return 1;
            end
        endcase
    endfunction

    function automatic void finish_expression();
        eval_result_t r;
        bit e;
        e = err_seen;
        while (!e && op_top > 0)
            if (!apply_top())
                e = 1;
        if (!e && num_top != 1)
            e = 1;
        r.err = e;
        r.value = e ? '0 : nums[0];
        expected_results.push_back(r);
        op_top = 0;
        num_top = 0;
        err_seen = 0;
    endfunction

    assign pending_results = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        eval_result_t exp_r;
        if (!rst_n)
        begin
            op_top = 0;
            num_top = 0;
            err_seen = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result_value !== exp_r.value)
                    begin
                        $error("result_value expected %0d actual %0d",
                               $signed(exp_r.value), result_value);
                        fail_count++;
                    end
                    if (error_flag !== exp_r.err)
                    begin
                        $error("error_flag expected %0d actual %0d", exp_r.err, error_flag);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (token_kind == KIND_END)
                    finish_expression();
                else if (!err_seen && !take_token(token_kind, token_value))
                    err_seen = 1;
            end
        end
    end

endmodule

// File: dv/tb.sv
module tb;
    import iiee_pkg::*;

    localparam int TokenTarget = 1600;
    localparam int CycleLimit  = 1000000;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [KindWidth-1:0]        token_kind;
    logic signed [DataWidth-1:0] token_value;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [DataWidth-1:0] result_value;
    logic                        error_flag;
    int                          fail_count;
    int                          pending_results;
    int                          cycle_count;
    bit                          calm;

    typedef struct {
        logic [KindWidth-1:0] kind;
        logic [DataWidth-1:0] value;
    } token_t;

    token_t token_queue[$];
    int sent_tokens;

    infix_integer_expression_evaluator u_top (.*);

    iiee_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("infix_integer_expression_evaluator test failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 12);

    function automatic logic [DataWidth-1:0] pick_value();
        logic [DataWidth-1:0] v;
        case ($urandom_range(5))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = $urandom_range(3) - 1;
            3: v = $urandom;
            default: v = $urandom_range(20) - 10;
        endcase
        return v;
    endfunction

    function automatic void add(input logic [KindWidth-1:0] k,
                                input logic [DataWidth-1:0] v = '0);
        token_t t;
        t.kind = k;
        t.value = v;
        token_queue.push_back(t);
    endfunction

    // operand: a number or a small bracketed subexpression
    function automatic void gen_operand(input int nest);
        if (nest < 3 && $urandom_range(5) == 0)
        begin
            add(KIND_OPEN);
            gen_expression(nest + 1);
            add(KIND_CLOSE);
        end
        else
            add(KIND_NUM, pick_value());
    endfunction

    function automatic void gen_expression(input int nest);
        int n;
        n = $urandom_range(4);
        gen_operand(nest);
        repeat (n)
        begin
            add(KindWidth'(KIND_ADD + $urandom_range(3)), $urandom);
            gen_operand(nest);
        end
    endfunction

    function automatic void gen_sentence();
        int n;
        if ($urandom_range(9) < 8)
            gen_expression(0);
        else
        begin
            n = $urandom_range(20);
            repeat (n)
                add(KindWidth'($urandom_range(6)), pick_value());
        end
        add(KIND_END, $urandom);
    endfunction

    task automatic send_all();
        token_t t;
        while (token_queue.size() > 0)
        begin
            t = token_queue.pop_front();
            while (!calm && $urandom_range(99) < 12)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            token_kind <= t.kind;
            token_value <= t.value;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sent_tokens++;
            @(negedge clk);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        token_kind = KIND_NUM;
        token_value = '0;
        cycle_count = 0;
        sent_tokens = 0;
        calm = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // extremes and wrap cases
        add(KIND_NUM, 32'h7fff_ffff); add(KIND_ADD); add(KIND_NUM, 1); add(KIND_END);
        add(KIND_NUM, 32'h8000_0000); add(KIND_DIV); add(KIND_NUM, 32'hffff_ffff);
        add(KIND_END);
        add(KIND_NUM, -7); add(KIND_DIV); add(KIND_NUM, 2); add(KIND_MUL);
        add(KIND_NUM, 32'h1234_5678); add(KIND_SUB); add(KIND_NUM, 5); add(KIND_END);
        // divide by zero, missing operand, stray close, unclosed open, empty
        add(KIND_NUM, 3); add(KIND_DIV); add(KIND_NUM, 0); add(KIND_END);
        add(KIND_NUM, 3); add(KIND_ADD); add(KIND_END);
        add(KIND_NUM, 3); add(KIND_CLOSE); add(KIND_END);
        add(KIND_OPEN); add(KIND_NUM, 3); add(KIND_END);
        add(KIND_END);
        add(KIND_NUM, 1); add(KIND_NUM, 2); add(KIND_END);
        // overflow on both stacks
        repeat (17) add(KIND_OPEN);
        add(KIND_END);
        repeat (17) add(KIND_NUM, 1);
        add(KIND_END);
        // sixteen nested brackets fill the operator stack exactly
        repeat (16) add(KIND_OPEN);
        add(KIND_NUM, 9);
        repeat (16) add(KIND_CLOSE);
        add(KIND_END);
        send_all();

        while (sent_tokens < TokenTarget)
        begin
            calm = (sent_tokens > 600 && sent_tokens < 800);
            gen_sentence();
            send_all();
        end
        calm = 0;

        while (pending_results > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("infix_integer_expression_evaluator test passed");
        else
            $display("infix_integer_expression_evaluator test failed");
        $finish;
    end

endmodule

// File: infix_integer_expression_evaluator.f
sv/iiee_pkg.sv
sv/infix_integer_expression_evaluator.sv
dv/iiee_checker.sv
dv/tb.sv
